FILE: design/top_k_hit_collector_unit_assert.svh
// Assertion macros used by the top-k hit collector port checker.
`ifndef TOP_K_HIT_COLLECTOR_UNIT_ASSERT_SVH
`define TOP_K_HIT_COLLECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TKHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TKHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tkhc_pkg.sv
// Types and constants of the top-k hit collector.
package tkhc_pkg;

    localparam int MAX_HITS = 16;
    localparam int IDX_W    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W    = $clog2(MAX_HITS + 1);

    localparam int DOC_W    = 32;
    localparam int KEY_W    = 64;
    localparam int ARR_W    = 32;
    localparam int WANT_W   = 7;
    localparam int CMP_W    = KEY_W + ARR_W;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DUMP = 1'b1;

    localparam logic REG_WANTED = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    localparam logic MODE_RANK = 1'b0;
    localparam logic MODE_SORT = 1'b1;

    localparam logic [WANT_W-1:0] WANTED_RESET = 7'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_ADD_SCAN,
        S_ADD_DECIDE,
        S_DUMP,
        S_DUMP_SCAN,
        S_DUMP_EMIT
    } t_state;

endpackage

FILE: design/top_k_hit_collector_unit.sv
// Top-k hit collector: keeps the best hits of a stream, reports them on demand.
// Commands are taken when start is high and busy is low; every result shows on the
// o_ result ports for one cycle with o_strobe high and cannot be held off, so the
// receiver must take it then. An add needs no scan when the store has room (or
// capacity is zero); else, with n held hits (n at most 16 at the default 16 slots),
// one comparator walks the slot registers one slot per cycle to find the worst held
// hit, then decides on the new hit. An add gives one result. For each reported hit
// a dump walks all n slots to pick the next one in arrival order, then shows it
// in its own emit state; an empty store gives a single result with o_valid_res low.
// The configuration channel is ready only while the block is idle.
module top_k_hit_collector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [tkhc_pkg::DOC_W-1:0]  i_doc_id,
    input  logic [tkhc_pkg::KEY_W-1:0]  i_sort_key,
    output logic                        o_strobe,
    output logic                        o_accepted,
    output logic                        o_valid_res,
    output logic [tkhc_pkg::ARR_W-1:0]  o_best_index,
    output logic [tkhc_pkg::DOC_W-1:0]  o_best_doc_id,
    output logic [tkhc_pkg::KEY_W-1:0]  o_best_key,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [tkhc_pkg::WANT_W-1:0] i_cfg_data
);

    localparam int IDX_W = tkhc_pkg::IDX_W;
    localparam int CNT_W = tkhc_pkg::CNT_W;
    localparam int KEY_W = tkhc_pkg::KEY_W;
    localparam int ARR_W = tkhc_pkg::ARR_W;
    localparam int DOC_W = tkhc_pkg::DOC_W;
    localparam int CMP_W = tkhc_pkg::CMP_W;

    tkhc_pkg::t_state r_state, n_state;

    // configuration
    logic [tkhc_pkg::WANT_W-1:0] r_wanted;
    logic                        r_mode;

    // store
    logic [ARR_W-1:0] r_slot_idx [tkhc_pkg::MAX_HITS];
    logic [DOC_W-1:0] r_slot_doc [tkhc_pkg::MAX_HITS];
    logic [KEY_W-1:0] r_slot_key [tkhc_pkg::MAX_HITS];
    logic [CNT_W-1:0] r_count, n_count;
    logic [ARR_W-1:0] r_arrival, n_arrival;

    // latched command
    logic [ARR_W-1:0] r_in_idx, n_in_idx;
    logic [DOC_W-1:0] r_in_doc, n_in_doc;
    logic [KEY_W-1:0] r_in_key, n_in_key;

    // scan state: candidate is the worst hit on add, the next hit to report on dump
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [ARR_W-1:0] r_c_idx, n_c_idx;
    logic [DOC_W-1:0] r_c_doc, n_c_doc;
    logic [KEY_W-1:0] r_c_key, n_c_key;
    logic [IDX_W-1:0] r_c_slot, n_c_slot;
    logic             r_found, n_found;
    logic             r_have_prev, n_have_prev;
    logic [ARR_W-1:0] r_prev_idx, n_prev_idx;
    logic [IDX_W-1:0] r_prev_slot, n_prev_slot;
    logic [CNT_W-1:0] r_emit, n_emit;

    // result register
    logic             r_o_strobe, n_o_strobe;
    logic             r_o_acc, n_o_acc;
    logic             r_o_valid, n_o_valid;
    logic [ARR_W-1:0] r_o_idx, n_o_idx;
    logic [DOC_W-1:0] r_o_doc, n_o_doc;
    logic [KEY_W-1:0] r_o_key, n_o_key;
    logic             r_o_last, n_o_last;

    logic             slot_we;
    logic [IDX_W-1:0] slot_addr;

    logic [ARR_W-1:0] rd_idx;
    logic [DOC_W-1:0] rd_doc;
    logic [KEY_W-1:0] rd_key;

    logic [CNT_W-1:0] cap;
    logic             ptr_last;
    logic             emit_last;
    logic             eligible;

    // shared comparator
    logic [CMP_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt;

    // maps a key so that a larger mapped value is a worse hit
    function automatic logic [KEY_W-1:0] worse_key(input logic mode,
                                                   input logic [KEY_W-1:0] k);
        return (mode == tkhc_pkg::MODE_SORT) ? k : ~k;
    endfunction

    assign rd_idx = r_slot_idx[r_ptr];
    assign rd_doc = r_slot_doc[r_ptr];
    assign rd_key = r_slot_key[r_ptr];

    assign cap = (r_wanted > tkhc_pkg::WANT_W'(tkhc_pkg::MAX_HITS))
               ? CNT_W'(tkhc_pkg::MAX_HITS) : r_wanted[CNT_W-1:0];
    assign ptr_last  = (CNT_W'(r_ptr) == (r_count - CNT_W'(1)));
    assign emit_last = ((r_emit + CNT_W'(1)) == r_count);
    assign eligible  = !r_have_prev || ({rd_idx, r_ptr} > {r_prev_idx, r_prev_slot});
    assign cmp_gt    = cmp_a > cmp_b;

    assign busy          = (r_state != tkhc_pkg::S_IDLE);
    assign o_cfg_ready   = !busy;
    assign o_strobe      = r_o_strobe;
    assign o_accepted    = r_o_acc;
    assign o_valid_res   = r_o_valid;
    assign o_best_index  = r_o_idx;
    assign o_best_doc_id = r_o_doc;
    assign o_best_key    = r_o_key;
    assign o_last        = r_o_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tkhc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_command == tkhc_pkg::CMD_DUMP)
                            ? tkhc_pkg::S_DUMP : tkhc_pkg::S_ADD;
                end
            end
            tkhc_pkg::S_ADD: begin
                if (r_count < cap || cap == '0 || r_count == '0) begin
                    n_state = tkhc_pkg::S_IDLE;
                end else if (r_count == CNT_W'(1)) begin
                    n_state = tkhc_pkg::S_ADD_DECIDE;
                end else begin
                    n_state = tkhc_pkg::S_ADD_SCAN;
                end
            end
            tkhc_pkg::S_ADD_SCAN: begin
                if (ptr_last) begin
                    n_state = tkhc_pkg::S_ADD_DECIDE;
                end
            end
            tkhc_pkg::S_ADD_DECIDE: n_state = tkhc_pkg::S_IDLE;
            tkhc_pkg::S_DUMP: begin
                n_state = (r_count == '0) ? tkhc_pkg::S_IDLE : tkhc_pkg::S_DUMP_SCAN;
            end
            tkhc_pkg::S_DUMP_SCAN: begin
                if (ptr_last) begin
                    n_state = tkhc_pkg::S_DUMP_EMIT;
                end
            end
            tkhc_pkg::S_DUMP_EMIT: begin
                n_state = emit_last ? tkhc_pkg::S_IDLE : tkhc_pkg::S_DUMP_SCAN;
            end
            default: n_state = tkhc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_arrival   = r_arrival;
        n_in_idx    = r_in_idx;
        n_in_doc    = r_in_doc;
        n_in_key    = r_in_key;
        n_ptr       = r_ptr;
        n_c_idx     = r_c_idx;
        n_c_doc     = r_c_doc;
        n_c_key     = r_c_key;
        n_c_slot    = r_c_slot;
        n_found     = r_found;
        n_have_prev = r_have_prev;
        n_prev_idx  = r_prev_idx;
        n_prev_slot = r_prev_slot;
        n_emit      = r_emit;
        n_o_strobe  = 1'b0;
        n_o_acc     = r_o_acc;
        n_o_valid   = r_o_valid;
        n_o_idx     = r_o_idx;
        n_o_doc     = r_o_doc;
        n_o_key     = r_o_key;
        n_o_last    = r_o_last;
        slot_we     = 1'b0;
        slot_addr   = r_ptr;
        cmp_a       = '0;
        cmp_b       = '0;

        case (r_state)
            tkhc_pkg::S_IDLE: begin
                if (start) begin
                    n_in_idx = r_arrival;
                    n_in_doc = i_doc_id;
                    n_in_key = i_sort_key;
                    n_ptr    = '0;
                end
            end
            tkhc_pkg::S_ADD: begin
                n_arrival = r_arrival + ARR_W'(1);
                n_o_idx   = r_in_idx;
                n_o_doc   = r_in_doc;
                n_o_key   = r_in_key;
                n_o_valid = 1'b0;
                n_o_last  = 1'b1;
                if (r_count < cap) begin
                    slot_we    = 1'b1;
                    slot_addr  = r_count[IDX_W-1:0];
                    n_count    = r_count + CNT_W'(1);
                    n_o_acc    = 1'b1;
                    n_o_strobe = 1'b1;
                end else if (cap == '0 || r_count == '0) begin
                    n_o_acc    = 1'b0;
                    n_o_strobe = 1'b1;
                end else begin
                    // slot 0 seeds the worst-hit search
                    n_c_idx  = rd_idx;
                    n_c_key  = rd_key;
                    n_c_slot = '0;
                    n_ptr    = IDX_W'(1);
                end
            end
            tkhc_pkg::S_ADD_SCAN: begin
                cmp_a = {worse_key(r_mode, rd_key), rd_idx};
                cmp_b = {worse_key(r_mode, r_c_key), r_c_idx};
                if (cmp_gt) begin
                    n_c_idx  = rd_idx;
                    n_c_key  = rd_key;
                    n_c_slot = r_ptr;
                end
                n_ptr = ptr_last ? '0 : r_ptr + IDX_W'(1);
            end
            tkhc_pkg::S_ADD_DECIDE: begin
                // key alone decides: a tie loses to the held hit
                cmp_a = {worse_key(r_mode, r_c_key), ARR_W'(0)};
                cmp_b = {worse_key(r_mode, r_in_key), ARR_W'(0)};
                slot_we    = cmp_gt;
                slot_addr  = r_c_slot;
                n_o_acc    = cmp_gt;
                n_o_strobe = 1'b1;
                n_ptr      = '0;
            end
            tkhc_pkg::S_DUMP: begin
                n_have_prev = 1'b0;
                n_found     = 1'b0;
                n_emit      = '0;
                n_ptr       = '0;
                if (r_count == '0) begin
                    n_o_strobe = 1'b1;
                    n_o_acc    = 1'b0;
                    n_o_valid  = 1'b0;
                    n_o_idx    = '0;
                    n_o_doc    = '0;
                    n_o_key    = '0;
                    n_o_last   = 1'b1;
                end
            end
            tkhc_pkg::S_DUMP_SCAN: begin
                // next in (arrival index, slot) order after the last reported hit
                cmp_a = {KEY_W'(0), r_c_idx};
                cmp_b = {KEY_W'(0), rd_idx};
                if (eligible && (!r_found || cmp_gt)) begin
                    n_c_idx  = rd_idx;
                    n_c_doc  = rd_doc;
                    n_c_key  = rd_key;
                    n_c_slot = r_ptr;
                    n_found  = 1'b1;
                end
                n_ptr = ptr_last ? '0 : r_ptr + IDX_W'(1);
            end
            tkhc_pkg::S_DUMP_EMIT: begin
                n_o_strobe  = 1'b1;
                n_o_acc     = 1'b0;
                n_o_valid   = 1'b1;
                n_o_idx     = r_c_idx;
                n_o_doc     = r_c_doc;
                n_o_key     = r_c_key;
                n_o_last    = emit_last;
                n_prev_idx  = r_c_idx;
                n_prev_slot = r_c_slot;
                n_have_prev = 1'b1;
                n_found     = 1'b0;
                n_emit      = r_emit + CNT_W'(1);
                n_ptr       = '0;
            end
            default: begin
                n_ptr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkhc_pkg::S_IDLE;
            r_wanted    <= tkhc_pkg::WANTED_RESET;
            r_mode      <= tkhc_pkg::MODE_RANK;
            r_count     <= '0;
            r_arrival   <= '0;
            r_ptr       <= '0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_emit      <= '0;
            r_o_strobe  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_arrival   <= n_arrival;
            r_ptr       <= n_ptr;
            r_found     <= n_found;
            r_have_prev <= n_have_prev;
            r_emit      <= n_emit;
            r_o_strobe  <= n_o_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tkhc_pkg::REG_WANTED: r_wanted <= i_cfg_data;
                    tkhc_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_idx    <= n_in_idx;
        r_in_doc    <= n_in_doc;
        r_in_key    <= n_in_key;
        r_c_idx     <= n_c_idx;
        r_c_doc     <= n_c_doc;
        r_c_key     <= n_c_key;
        r_c_slot    <= n_c_slot;
        r_prev_idx  <= n_prev_idx;
        r_prev_slot <= n_prev_slot;
        r_o_acc     <= n_o_acc;
        r_o_valid   <= n_o_valid;
        r_o_idx     <= n_o_idx;
        r_o_doc     <= n_o_doc;
        r_o_key     <= n_o_key;
        r_o_last    <= n_o_last;
        if (slot_we) begin
            r_slot_idx[slot_addr] <= r_in_idx;
            r_slot_doc[slot_addr] <= r_in_doc;
            r_slot_key[slot_addr] <= r_in_key;
        end
    end

endmodule

FILE: design/tkhc_checker.sv
// Port-level checker for the top-k hit collector, bound to the top level.
`include "top_k_hit_collector_unit_assert.svh"

module tkhc_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_accepted,
    input logic o_valid_res,
    input logic o_last
);

    // a taken command always makes the block busy in the next cycle
    `TKHC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "command taken but not busy")

    // more beats of a dump follow, so the block stays busy
    `TKHC_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, busy, "dump beat while idle")

    // the final beat frees the block
    `TKHC_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !busy, "busy after last beat")

    // an accepted add is a single beat and carries no dump mark
    `TKHC_ASSERT_NOW(a_acc_shape, i_clk, i_rst_n, o_strobe && o_accepted, o_last && !o_valid_res, "bad add")

endmodule

bind top_k_hit_collector_unit tkhc_port_checker u_tkhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_accepted  (o_accepted),
    .o_valid_res (o_valid_res),
    .o_last      (o_last)
);

FILE: verif/tkhc_checker.sv
`timescale 1ns / 100ps
// Predictor and scoreboard for the top-k hit collector: models the store, compares result beats.
module tkhc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_command,
    input  logic [tkhc_pkg::DOC_W-1:0]  i_doc_id,
    input  logic [tkhc_pkg::KEY_W-1:0]  i_sort_key,
    input  logic                        i_strobe,
    input  logic                        i_accepted,
    input  logic                        i_valid_res,
    input  logic [tkhc_pkg::ARR_W-1:0]  i_best_index,
    input  logic [tkhc_pkg::DOC_W-1:0]  i_best_doc_id,
    input  logic [tkhc_pkg::KEY_W-1:0]  i_best_key,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [tkhc_pkg::WANT_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);
    localparam int MAX_HITS = tkhc_pkg::MAX_HITS;
    localparam int ARR_W    = tkhc_pkg::ARR_W;
    localparam int DOC_W    = tkhc_pkg::DOC_W;
    localparam int KEY_W    = tkhc_pkg::KEY_W;
    localparam int WANT_W   = tkhc_pkg::WANT_W;

    typedef struct packed {
        logic             accepted;
        logic             valid_res;
        logic [ARR_W-1:0] index;
        logic [DOC_W-1:0] doc;
        logic [KEY_W-1:0] key;
        logic             last;
    } t_hit_beat;

    t_hit_beat expected_hits [$];

    // mirror of the block state
    logic [WANT_W-1:0] wanted_hits;
    logic              order_mode;
    int unsigned       held_count;
    logic [ARR_W-1:0]  arrival_count;
    logic [ARR_W-1:0]  slot_index [MAX_HITS];
    logic [DOC_W-1:0]  slot_doc   [MAX_HITS];
    logic [KEY_W-1:0]  slot_key   [MAX_HITS];

    // hit a ranks below hit b; equal keys: later arrival ranks lower
    function automatic bit hit_is_worse(input logic mode,
                                        input logic [KEY_W-1:0] key_a,
                                        input logic [ARR_W-1:0] idx_a,
                                        input logic [KEY_W-1:0] key_b,
                                        input logic [ARR_W-1:0] idx_b);
        if (key_a != key_b) begin
            return (mode == tkhc_pkg::MODE_SORT) ? (key_a > key_b) : (key_a < key_b);
        end
        return idx_a > idx_b;
    endfunction

    always @(posedge i_clk) begin : model_step
        t_hit_beat        got;
        t_hit_beat        exp_beat;
        t_hit_beat        beat;
        int unsigned      cap;
        int unsigned      n;
        int unsigned      w;
        int unsigned      i;
        int unsigned      j;
        int unsigned      s;
        int unsigned      arrival_order [MAX_HITS];
        logic [ARR_W-1:0] idx;
        logic             acc;

        if (!i_rst_n) begin
            wanted_hits   = tkhc_pkg::WANTED_RESET;
            order_mode    = tkhc_pkg::MODE_RANK;
            held_count    = 0;
            arrival_count = '0;
            expected_hits.delete();
        end else begin
            // compare first: a new command may be taken on the edge of a final beat
            if (i_strobe) begin
                got = {i_accepted, i_valid_res, i_best_index, i_best_doc_id, i_best_key, i_last};
                o_result_count++;
                if (expected_hits.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected result beat acc=%0b vld=%0b idx=%0d doc=%h key=%h last=%0b",
                                 $time, got.accepted, got.valid_res, got.index, got.doc,
                                 got.key, got.last);
                    end
                end else begin
                    exp_beat = expected_hits.pop_front();
                    if (got.accepted !== exp_beat.accepted || got.valid_res !== exp_beat.valid_res ||
                        got.index !== exp_beat.index || got.doc !== exp_beat.doc ||
                        got.key !== exp_beat.key || got.last !== exp_beat.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected acc=%0b vld=%0b idx=%0d doc=%h key=%h last=%0b",
                                     exp_beat.accepted, exp_beat.valid_res, exp_beat.index,
                                     exp_beat.doc, exp_beat.key, exp_beat.last);
                            $display("  actual   acc=%0b vld=%0b idx=%0d doc=%h key=%h last=%0b",
                                     got.accepted, got.valid_res, got.index, got.doc,
                                     got.key, got.last);
                        end
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == tkhc_pkg::REG_WANTED) begin
                    wanted_hits = i_cfg_data;
                end else begin
                    order_mode = i_cfg_data[0];
                end
            end

            if (i_start && !i_busy) begin
                n = held_count;
                if (i_command == tkhc_pkg::CMD_ADD) begin
                    cap = (wanted_hits > MAX_HITS) ? MAX_HITS : wanted_hits;
                    idx = arrival_count;
                    arrival_count = arrival_count + ARR_W'(1);
                    acc = 1'b0;
                    if (n < cap) begin
                        slot_index[n] = idx;
                        slot_doc[n]   = i_doc_id;
                        slot_key[n]   = i_sort_key;
                        held_count    = n + 1;
                        acc           = 1'b1;
                    end else if (cap > 0 && n > 0) begin
                        // capacity may sit below held_count: still only replace
                        w = 0;
                        for (i = 1; i < n; i++) begin
                            if (hit_is_worse(order_mode, slot_key[i], slot_index[i],
                                             slot_key[w], slot_index[w])) begin
                                w = i;
                            end
                        end
                        if (slot_key[w] != i_sort_key &&
                            hit_is_worse(order_mode, slot_key[w], slot_index[w],
                                         i_sort_key, idx)) begin
                            slot_index[w] = idx;
                            slot_doc[w]   = i_doc_id;
                            slot_key[w]   = i_sort_key;
                            acc           = 1'b1;
                        end
                    end
                    beat = {acc, 1'b0, idx, i_doc_id, i_sort_key, 1'b1};
                    expected_hits.push_back(beat);
                end else if (n == 0) begin
                    beat      = '0;
                    beat.last = 1'b1;
                    expected_hits.push_back(beat);
                end else begin
                    // stable insertion sort of the slots by arrival index
                    for (i = 0; i < n; i++) begin
                        s = i;
                        j = i;
                        while (j > 0 && slot_index[arrival_order[j-1]] > slot_index[s]) begin
                            arrival_order[j] = arrival_order[j-1];
                            j--;
                        end
                        arrival_order[j] = s;
                    end
                    for (i = 0; i < n; i++) begin
                        s    = arrival_order[i];
                        beat = {1'b0, 1'b1, slot_index[s], slot_doc[s], slot_key[s],
                                (i + 1 == n) ? 1'b1 : 1'b0};
                        expected_hits.push_back(beat);
                    end
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the top-k hit collector: clock, reset, command and register stimulus, verdict.
module tb_top;
    localparam int DOC_W  = tkhc_pkg::DOC_W;
    localparam int KEY_W  = tkhc_pkg::KEY_W;
    localparam int ARR_W  = tkhc_pkg::ARR_W;
    localparam int WANT_W = tkhc_pkg::WANT_W;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic              i_command   = tkhc_pkg::CMD_ADD;
    logic [DOC_W-1:0]  i_doc_id    = '0;
    logic [KEY_W-1:0]  i_sort_key  = '0;
    logic              o_strobe;
    logic              o_accepted;
    logic              o_valid_res;
    logic [ARR_W-1:0]  o_best_index;
    logic [DOC_W-1:0]  o_best_doc_id;
    logic [KEY_W-1:0]  o_best_key;
    logic              o_last;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = tkhc_pkg::REG_WANTED;
    logic [WANT_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int hits_pending;
    int beats_checked;
    int n_adds  = 0;
    int n_dumps = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    top_k_hit_collector_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_doc_id      (i_doc_id),
        .i_sort_key    (i_sort_key),
        .o_strobe      (o_strobe),
        .o_accepted    (o_accepted),
        .o_valid_res   (o_valid_res),
        .o_best_index  (o_best_index),
        .o_best_doc_id (o_best_doc_id),
        .o_best_key    (o_best_key),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tkhc_checker hit_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_doc_id       (i_doc_id),
        .i_sort_key     (i_sort_key),
        .i_strobe       (o_strobe),
        .i_accepted     (o_accepted),
        .i_valid_res    (o_valid_res),
        .i_best_index   (o_best_index),
        .i_best_doc_id  (o_best_doc_id),
        .i_best_key     (o_best_key),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (hits_pending),
        .o_result_count (beats_checked)
    );

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_command(input logic cmd, input logic [DOC_W-1:0] doc,
                                input logic [KEY_W-1:0] key);
        start      <= 1'b1;
        i_command  <= cmd;
        i_doc_id   <= doc;
        i_sort_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == tkhc_pkg::CMD_ADD) n_adds++;
        else n_dumps++;
    endtask

    task automatic wait_drained();
        while (hits_pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // drop start for a gap, optionally waiting for every result first
    task automatic hold_off(input int gap, input bit drain);
        if (gap > 0 || drain) begin
            start <= 1'b0;
            if (drain) wait_drained();
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [WANT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // small keys give plenty of ties
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(0, 7));
            5:       return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic run_phase(input logic [WANT_W-1:0] wanted, input logic mode,
                             input int n_items, input bit no_idle);
        logic             cmd;
        logic [DOC_W-1:0] doc;
        write_reg(tkhc_pkg::REG_WANTED, wanted);
        write_reg(tkhc_pkg::REG_MODE, WANT_W'(mode));
        for (int k = 0; k < n_items; k++) begin
            cmd = ($urandom_range(0, 7) == 0) ? tkhc_pkg::CMD_DUMP : tkhc_pkg::CMD_ADD;
            doc = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                 : DOC_W'($urandom);
            send_command(cmd, doc, pick_key());
            hold_off(no_idle ? 0 : pick_gap(), $urandom_range(0, 39) == 0);
        end
        hold_off(0, 1'b1);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty store dump
        send_command(tkhc_pkg::CMD_DUMP, '1, '1);
        hold_off(0, 1'b1);

        // two slots, rank mode: ties lose, strictly better replaces the worst
        write_reg(tkhc_pkg::REG_WANTED, 7'd2);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0000, 64'd5);
        send_command(tkhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 64'd5);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0001, 64'd5);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0002, 64'd4);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0003, 64'd6);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0004, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0005, 64'd0);
        send_command(tkhc_pkg::CMD_DUMP, '0, '0);
        hold_off(0, 1'b1);

        // flip to sort mode while holding hits
        write_reg(tkhc_pkg::REG_MODE, WANT_W'(tkhc_pkg::MODE_SORT));
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0006, 64'd0);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0007, 64'd0);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0008, 64'd0);
        send_command(tkhc_pkg::CMD_DUMP, '0, '0);
        hold_off(0, 1'b1);

        // zero capacity rejects, store keeps its hits
        write_reg(tkhc_pkg::REG_WANTED, 7'd0);
        send_command(tkhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 64'd0);
        send_command(tkhc_pkg::CMD_DUMP, '0, '0);
        hold_off(0, 1'b1);

        // capacity below held count: replace only
        write_reg(tkhc_pkg::REG_WANTED, 7'd1);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_0009, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(tkhc_pkg::CMD_ADD, 32'h0000_000A, 64'd0);
        send_command(tkhc_pkg::CMD_DUMP, '0, '0);
        hold_off(0, 1'b1);

        run_phase(7'd16, tkhc_pkg::MODE_RANK, 50, 1'b0);
        run_phase(7'd64, tkhc_pkg::MODE_SORT, 50, 1'b0);
        run_phase(7'd1,  tkhc_pkg::MODE_RANK, 40, 1'b0);
        run_phase(7'd0,  tkhc_pkg::MODE_SORT, 30, 1'b0);
        run_phase(7'd5,  tkhc_pkg::MODE_SORT, 50, 1'b0);
        run_phase(7'd63, tkhc_pkg::MODE_RANK, 50, 1'b0);
        run_phase(7'd3,  tkhc_pkg::MODE_RANK, 45, 1'b1);
        run_phase(7'd64, tkhc_pkg::MODE_SORT, 45, 1'b0);

        repeat (20) @(negedge i_clk);
        $display("Run summary: %0d adds and %0d dumps, %0d result beats checked.",
                 n_adds, n_dumps, beats_checked);
        $display("Covered both order modes, capacities 0 to 64, shrink below held, key ties.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding", hits_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
